@@ sv/ptv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the polygon T-junction vertex insert block.
// No dependencies; every other file refers to this package by scoped names.
package ptv_pkg;

  localparam int COORD_W = 20;   // coordinate field width
  localparam int MAG_W   = 21;   // magnitude of a coordinate difference
  localparam int CH_W    = 22;   // operand chunk of the shared multiplier
  localparam int SUM_W   = 44;   // dot and squared-length sums
  localparam int T_W     = 61;   // threshold times first squared length
  localparam int ACC_W   = 106;  // wide accumulator
  localparam int SH_W    = 2;    // chunk shift of one partial product
  localparam int STEP_W  = 5;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_ON_VERTEX = 3'd2;
  localparam logic [2:0] ST_NO_EDGE   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic        REG_TOL   = 1'b0;
  localparam logic        REG_MCS   = 1'b1;
  localparam logic [15:0] TOL_RESET = 16'd8;
  localparam logic [16:0] MCS_RESET = 17'd65405;

  // last step of each phase of the edge test
  localparam logic [STEP_W-1:0] STEP_SUMS_END = 5'd8;
  localparam logic [STEP_W-1:0] STEP_LAST     = 5'd20;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEST   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vertex_t;

  typedef struct packed {
    logic [15:0] tol;
    logic [16:0] mcs;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] x;
    logic [CH_W-1:0] y;
    logic [SH_W-1:0] sh;
  } mac_op_t;

endpackage

@@ sv/ptv_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channels for request and result beats.
// Depends on ptv_pkg for field widths.
interface ptv_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         operation;
  logic signed [ptv_pkg::COORD_W-1:0] point_x;
  logic signed [ptv_pkg::COORD_W-1:0] point_y;
  logic signed [ptv_pkg::COORD_W-1:0] point_z;
  logic [9:0]                         read_index;
  modport source(output valid, operation, point_x, point_y, point_z, read_index, input ready);
  modport sink(input valid, operation, point_x, point_y, point_z, read_index, output ready);
endinterface

interface ptv_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         status;
  logic [9:0]                         position;
  logic signed [ptv_pkg::COORD_W-1:0] vertex_x;
  logic signed [ptv_pkg::COORD_W-1:0] vertex_y;
  logic signed [ptv_pkg::COORD_W-1:0] vertex_z;
  logic [10:0]                        vertex_count;
  modport source(output valid, status, position, vertex_x, vertex_y, vertex_z, vertex_count,
                 input ready);
  modport sink(input valid, status, position, vertex_x, vertex_y, vertex_z, vertex_count,
               output ready);
endinterface

@@ sv/ptv_regs.sv @@
`timescale 1ns / 1ps
// APB register file: tolerance and squared cosine threshold.
// Depends on ptv_pkg.
module ptv_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output ptv_pkg::cfg_t cfg
);

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tol <= ptv_pkg::TOL_RESET;
      cfg.mcs <= ptv_pkg::MCS_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ptv_pkg::REG_MCS) begin
        cfg.mcs <= pwdata[16:0];
      end else begin
        cfg.tol <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == ptv_pkg::REG_TOL) ? {16'b0, cfg.tol} : {15'b0, cfg.mcs};

endmodule

@@ sv/ptv_mac.sv @@
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: one 22x22 product, shifted by whole chunks,
// added to the selected accumulator. Depends on ptv_pkg.
module ptv_mac (
  input  ptv_pkg::mac_op_t               op,
  input  logic [ptv_pkg::ACC_W-1:0]      acc_in,
  output logic [ptv_pkg::ACC_W-1:0]      acc_out
);

  logic [2*ptv_pkg::CH_W-1:0] prod;
  logic [ptv_pkg::ACC_W-1:0]  shifted;

  assign prod    = op.x * op.y;
  assign shifted = ptv_pkg::ACC_W'(prod) << (ptv_pkg::CH_W * op.sh);
  assign acc_out = acc_in + shifted;

endmodule

@@ sv/polygon_tjunction_vertex_insert.sv @@
`timescale 1ns / 1ps
// Top level: vertex ring memory, edge-walk sequencer and result register.
// Depends on ptv_pkg, ptv_if, ptv_regs and ptv_mac.
//
//  channel   dir   handshake          content
//  req       in    valid/ready        operation, point_x/y/z, read_index
//  rsp       out   valid/ready        status, position, vertex_x/y/z, vertex_count
//  apb       in    psel/penable       tolerance, squared cosine threshold
//
// Test walks the edges with the single shared 22x22 multiplier, leaving an edge
// early when the point matches an end or when the dot is not positive; an insert
// first shifts each later vertex up one slot. req.ready is low while an item is
// in work or its result beat has not been taken. Synchronous reset empties the
// ring; the vertex memory itself is not cleared.
module polygon_tjunction_vertex_insert #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ptv_req_if.sink     req,
  ptv_rsp_if.source   rsp
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W = ptv_pkg::SUM_W;
  localparam int ACC_W = ptv_pkg::ACC_W;
  localparam int CH_W  = ptv_pkg::CH_W;
  localparam int MAG_W = ptv_pkg::MAG_W;

  typedef enum logic [12:0] {
    S_IDLE = 13'h0001, S_EA  = 13'h0002, S_EB  = 13'h0004, S_EC  = 13'h0008,
    S_SAME = 13'h0010, S_MAC = 13'h0020, S_DOT = 13'h0040, S_CMP = 13'h0080,
    S_SHR  = 13'h0100, S_SHW = 13'h0200, S_INS = 13'h0400, S_RD  = 13'h0800,
    S_RDW  = 13'h1000
  } state_t;

  typedef enum logic [2:0] {
    D_POS, D_NEG, D_LEN1, D_LEN2, D_LACC, D_TACC, D_RACC
  } dst_t;

  ptv_pkg::cfg_t cfg;

  ptv_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  state_t                state;
  logic [AW-1:0]         i;
  logic [AW-1:0]         k;
  logic [CW-1:0]         count;
  ptv_pkg::vertex_t      va, vb, pt;
  logic [9:0]            idx;
  logic [ptv_pkg::STEP_W-1:0] step;
  logic [SUM_W-1:0]      pos, neg, len1, len2, dot;
  logic [ACC_W-1:0]      lacc, racc;
  logic [ptv_pkg::T_W-1:0] tacc;
  logic                  res_valid;
  logic [2:0]            res_status;
  logic [9:0]            res_pos;
  ptv_pkg::vertex_t      res_vtx;

  ptv_pkg::vertex_t      mem [MAX_VERTICES];
  ptv_pkg::vertex_t      rdata;
  logic [AW-1:0]         raddr, waddr;
  logic                  mem_we;
  ptv_pkg::vertex_t      wdata;

  logic                  accept, last_edge, full, same_a, same_b, between, idx_ok;
  logic [AW-1:0]         nx;
  ptv_pkg::vertex_t      req_pt;

  function automatic logic signed [ptv_pkg::COORD_W-1:0] coord(ptv_pkg::vertex_t v,
                                                               logic [1:0] a);
    logic signed [ptv_pkg::COORD_W-1:0] c;
    case (a)
      2'd0:    c = v.x;
      2'd1:    c = v.y;
      default: c = v.z;
    endcase
    return c;
  endfunction

  function automatic logic [MAG_W-1:0] sdiff(logic signed [ptv_pkg::COORD_W-1:0] a,
                                             logic signed [ptv_pkg::COORD_W-1:0] b);
    return {a[ptv_pkg::COORD_W-1], a} - {b[ptv_pkg::COORD_W-1], b};
  endfunction

  function automatic logic [MAG_W-1:0] mag(logic [MAG_W-1:0] d);
    return d[MAG_W-1] ? (~d + 1'b1) : d;
  endfunction

  function automatic logic same(ptv_pkg::vertex_t a, ptv_pkg::vertex_t b, logic [15:0] tol);
    logic ok;
    ok = 1'b1;
    for (int a_i = 0; a_i < 3; a_i++) begin
      if (mag(sdiff(coord(a, 2'(a_i)), coord(b, 2'(a_i)))) > MAG_W'(tol)) ok = 1'b0;
    end
    return ok;
  endfunction

  assign req_pt    = '{z: req.point_z, y: req.point_y, x: req.point_x};
  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && !res_valid;
  assign last_edge = ((CW'(i) + 1'b1) == count);
  assign nx        = last_edge ? '0 : i + 1'b1;
  assign full      = (count >= CW'(MAX_VERTICES));
  assign same_a    = same(va, pt, cfg.tol);
  assign same_b    = same(vb, pt, cfg.tol);
  assign between   = (lacc << 16) > racc;
  assign idx_ok    = (13'(idx) < 13'(count)) && (13'(idx) < 13'(MAX_VERTICES));

  // Per-axis operands for the sum steps
  logic [1:0]       ax;
  logic [MAG_W-1:0] d1, d2, m1, m2;

  always_comb begin
    case (step)
      5'd0, 5'd1, 5'd2: ax = step[1:0];
      5'd3, 5'd4, 5'd5: ax = 2'(step - 5'd3);
      5'd6, 5'd7, 5'd8: ax = 2'(step - 5'd6);
      default:          ax = 2'd0;
    endcase
  end

  assign d1 = sdiff(coord(va, ax), coord(pt, ax));
  assign d2 = sdiff(coord(pt, ax), coord(vb, ax));
  assign m1 = mag(d1);
  assign m2 = mag(d2);

  // Step table of the shared multiplier
  ptv_pkg::mac_op_t mop;
  dst_t             dst;
  logic [ACC_W-1:0] acc_in, acc_out;
  logic [4:0]       j;
  logic [3*CH_W-1:0] tpad;

  assign tpad = (3*CH_W)'(tacc);

  always_comb begin
    mop = '0;
    dst = D_POS;
    j   = 5'd0;
    case (step)
      5'd0, 5'd1, 5'd2: begin
        mop.x = CH_W'(m1);
        mop.y = CH_W'(m2);
        dst   = (d1[MAG_W-1] != d2[MAG_W-1]) ? D_NEG : D_POS;
      end
      5'd3, 5'd4, 5'd5: begin
        mop.x = CH_W'(m1);
        mop.y = CH_W'(m1);
        dst   = D_LEN1;
      end
      5'd6, 5'd7, 5'd8: begin
        mop.x = CH_W'(m2);
        mop.y = CH_W'(m2);
        dst   = D_LEN2;
      end
      5'd9, 5'd10, 5'd11, 5'd12: begin
        j      = step - 5'd9;
        mop.x  = j[1] ? dot[2*CH_W-1:CH_W] : dot[CH_W-1:0];
        mop.y  = j[0] ? dot[2*CH_W-1:CH_W] : dot[CH_W-1:0];
        mop.sh = 2'(j[1]) + 2'(j[0]);
        dst    = D_LACC;
      end
      5'd13, 5'd14: begin
        j      = step - 5'd13;
        mop.x  = CH_W'(cfg.mcs);
        mop.y  = j[0] ? len1[2*CH_W-1:CH_W] : len1[CH_W-1:0];
        mop.sh = 2'(j[0]);
        dst    = D_TACC;
      end
      5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20: begin
        j      = step - 5'd15;
        case (j[2:1])
          2'd0:    mop.x = tpad[CH_W-1:0];
          2'd1:    mop.x = tpad[2*CH_W-1:CH_W];
          default: mop.x = tpad[3*CH_W-1:2*CH_W];
        endcase
        mop.y  = j[0] ? len2[2*CH_W-1:CH_W] : len2[CH_W-1:0];
        mop.sh = j[2:1] + 2'(j[0]);
        dst    = D_RACC;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (dst)
      D_POS:   acc_in = ACC_W'(pos);
      D_NEG:   acc_in = ACC_W'(neg);
      D_LEN1:  acc_in = ACC_W'(len1);
      D_LEN2:  acc_in = ACC_W'(len2);
      D_LACC:  acc_in = lacc;
      D_TACC:  acc_in = ACC_W'(tacc);
      default: acc_in = racc;
    endcase
  end

  ptv_mac u_mac (.op(mop), .acc_in(acc_in), .acc_out(acc_out));

  // Memory ports
  always_comb begin
    case (state)
      S_EB:    raddr = nx;
      S_SHR:   raddr = k - 1'b1;
      S_RD:    raddr = AW'(idx);
      default: raddr = i;
    endcase
    mem_we = 1'b0;
    waddr  = AW'(count);
    wdata  = req_pt;
    case (state)
      S_IDLE: mem_we = accept && (req.operation == ptv_pkg::OP_APPEND) && !full;
      S_SHW: begin
        mem_we = 1'b1;
        waddr  = k;
        wdata  = rdata;
      end
      S_INS: begin
        mem_we = 1'b1;
        waddr  = nx;
        wdata  = pt;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            pt      <= req_pt;
            idx     <= req.read_index;
            i       <= '0;
            res_vtx <= '0;
            res_pos <= '0;
            case (ptv_pkg::op_t'(req.operation))
              ptv_pkg::OP_CLEAR: begin
                count      <= '0;
                res_status <= ptv_pkg::ST_DONE;
                res_valid  <= 1'b1;
              end
              ptv_pkg::OP_APPEND: begin
                res_pos   <= 10'(count);
                res_valid <= 1'b1;
                if (full) begin
                  res_status <= ptv_pkg::ST_FULL;
                end else begin
                  res_status <= ptv_pkg::ST_DONE;
                  count      <= count + 1'b1;
                end
              end
              ptv_pkg::OP_TEST: begin
                if (count == '0) begin
                  res_status <= ptv_pkg::ST_NO_EDGE;
                  res_valid  <= 1'b1;
                end else begin
                  state <= S_EA;
                end
              end
              default: state <= S_RD;
            endcase
          end
        end
        S_EA: state <= S_EB;
        S_EB: begin
          va    <= rdata;
          state <= S_EC;
        end
        S_EC: begin
          vb    <= rdata;
          state <= S_SAME;
        end
        S_SAME: begin
          pos  <= '0;
          neg  <= '0;
          len1 <= '0;
          len2 <= '0;
          lacc <= '0;
          tacc <= '0;
          racc <= '0;
          step <= '0;
          if (same_a || same_b) begin
            res_status <= ptv_pkg::ST_ON_VERTEX;
            res_pos    <= same_a ? 10'(i) : 10'(nx);
            res_valid  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            state <= S_MAC;
          end
        end
        S_MAC: begin
          case (dst)
            D_POS:   pos  <= SUM_W'(acc_out);
            D_NEG:   neg  <= SUM_W'(acc_out);
            D_LEN1:  len1 <= SUM_W'(acc_out);
            D_LEN2:  len2 <= SUM_W'(acc_out);
            D_LACC:  lacc <= acc_out;
            D_TACC:  tacc <= ptv_pkg::T_W'(acc_out);
            default: racc <= acc_out;
          endcase
          step <= step + 1'b1;
          if (step == ptv_pkg::STEP_SUMS_END) state <= S_DOT;
          else if (step == ptv_pkg::STEP_LAST) state <= S_CMP;
        end
        S_DOT, S_CMP: begin
          if ((state == S_DOT) && (pos > neg)) begin
            dot   <= pos - neg;
            state <= S_MAC;
          end else if ((state == S_CMP) && between) begin
            res_pos <= 10'(nx);
            if (full) begin
              res_status <= ptv_pkg::ST_FULL;
              res_valid  <= 1'b1;
              state      <= S_IDLE;
            end else begin
              k     <= AW'(count);
              state <= S_SHR;
            end
          end else if (last_edge) begin
            res_status <= ptv_pkg::ST_NO_EDGE;
            res_valid  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            i     <= i + 1'b1;
            state <= S_EA;
          end
        end
        S_SHR: state <= S_SHW;
        S_SHW: begin
          // move one vertex up, stop once the slot after the edge start is free
          k <= k - 1'b1;
          if ((k - 1'b1) > nx) state <= S_SHR;
          else state <= S_INS;
        end
        S_INS: begin
          count      <= count + 1'b1;
          res_status <= ptv_pkg::ST_INSERTED;
          res_valid  <= 1'b1;
          state      <= S_IDLE;
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          res_status <= ptv_pkg::ST_DONE;
          res_pos    <= idx;
          res_vtx    <= idx_ok ? rdata : '0;
          res_valid  <= 1'b1;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid        = res_valid;
  assign rsp.status       = res_status;
  assign rsp.position     = res_pos;
  assign rsp.vertex_x     = res_vtx.x;
  assign rsp.vertex_y     = res_vtx.y;
  assign rsp.vertex_z     = res_vtx.z;
  assign rsp.vertex_count = 11'(count);

endmodule

@@ sv/ptv_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the vertex insert block, attached by bind.
// Depends on ptv_pkg and polygon_tjunction_vertex_insert.
module ptv_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [2:0]                         status,
  input logic [9:0]                         position,
  input logic signed [ptv_pkg::COORD_W-1:0] vertex_x,
  input logic signed [ptv_pkg::COORD_W-1:0] vertex_y,
  input logic signed [ptv_pkg::COORD_W-1:0] vertex_z
);

  // one item at a time: no beat right after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while previous item in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(position)))
    else $error("stalled result beat changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status <= ptv_pkg::ST_FULL))
    else $error("status code out of range");

  a_vertex_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == ptv_pkg::ST_INSERTED || status == ptv_pkg::ST_ON_VERTEX ||
                   status == ptv_pkg::ST_NO_EDGE || status == ptv_pkg::ST_FULL))
    |-> (vertex_x == '0 && vertex_y == '0 && vertex_z == '0))
    else $error("vertex fields set on a non-read result");

  a_no_edge_pos: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ptv_pkg::ST_NO_EDGE) |-> (position == '0))
    else $error("no-edge result with nonzero position");

endmodule

bind polygon_tjunction_vertex_insert ptv_checker u_ptv_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.status), .position(rsp.position),
  .vertex_x(rsp.vertex_x), .vertex_y(rsp.vertex_y), .vertex_z(rsp.vertex_z)
);
